// ===== sv/vector2_magnitude_clamp_assert.svh =====
// assertion macros for the vector magnitude clamp
// used by the top level only
`ifndef VECTOR2_MAGNITUDE_CLAMP_ASSERT_SVH
`define VECTOR2_MAGNITUDE_CLAMP_ASSERT_SVH

// a held output word stays put while stalled
`define VMC_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error("vmc hold");

// implication between signals on one edge
`define VMC_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (a) |-> (b)) else $error("vmc implication");

`endif

// ===== sv/vmc_pkg.sv =====
// shared types and constants for the vector magnitude clamp
// used by vmc_sqrt and the top level of the block, and by the testbench
package vmc_pkg;
    localparam int FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic [30:0]        limit_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               clamped;
    } t_out_word;

    // per-stage side data carried with each word
    typedef struct packed {
        logic [31:0] raw_x;
        logic [31:0] raw_y;
        logic [31:0] ax;
        logic [31:0] ay;
        logic        nx;
        logic        ny;
        logic [30:0] lim;
    } t_side;
endpackage

// ===== sv/vmc_sqrt.sv =====
// pipelined restoring square root, one result bit per stage
// depends on vmc_pkg
module vmc_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_rad,
    input  vmc_pkg::t_side i_side,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output vmc_pkg::t_side o_side
);
    localparam int N = 32;

    logic [N:0]          r_v;
    logic [63:0]         r_rem  [N+1];
    logic [63:0]         r_rad  [N+1];
    logic [31:0]         r_root [N+1];
    vmc_pkg::t_side      r_side [N+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = '0;
        r_rad[0]  = i_rad;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [65:0] n_rem;
        logic [65:0] n_trial;
        logic        n_ok;
        always_comb begin
            n_rem   = {r_rem[s], r_rad[s][63:62]};
            n_trial = {32'd0, r_root[s], 2'b01};
            n_ok    = n_rem >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_rem[s+1]  <= n_ok ? 64'(n_rem - n_trial) : n_rem[63:0];
                r_rad[s+1]  <= {r_rad[s][61:0], 2'b00};
                r_root[s+1] <= {r_root[s][30:0], n_ok};
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_root[N];
    assign o_side  = r_side[N];
endmodule

// ===== sv/vmc_div.sv =====
// pipelined restoring divider, 63-bit dividend by 32-bit divisor
// self-contained; uses no package
module vmc_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [62:0]   i_num,
    input  logic [31:0]   i_den,
    input  logic          i_neg,
    output logic          o_valid,
    output logic [31:0]   o_quo,
    output logic          o_neg
);
    localparam int N = 63;

    logic [N:0]    r_v;
    logic [32:0]   r_rem [N+1];
    logic [62:0]   r_num [N+1];
    logic [31:0]   r_den [N+1];
    logic [31:0]   r_quo [N+1];
    logic          r_neg [N+1];

    always_comb begin
        r_v[0]   = i_valid;
        r_rem[0] = '0;
        r_num[0] = i_num;
        r_den[0] = i_den;
        r_quo[0] = '0;
        r_neg[0] = i_neg;
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [33:0] n_sh;
        logic        n_ok;
        always_comb begin
            n_sh = {r_rem[s], r_num[s][62]};
            n_ok = n_sh >= {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_rem[s+1] <= n_ok ? 33'(n_sh - {2'b00, r_den[s]}) : n_sh[32:0];
                r_num[s+1] <= {r_num[s][61:0], 1'b0};
                r_den[s+1] <= r_den[s];
                r_quo[s+1] <= {r_quo[s][30:0], n_ok};
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_quo   = r_neg[N] ? 32'(-r_quo[N]) : r_quo[N];
    assign o_neg   = r_neg[N];
endmodule

// ===== sv/vector2_magnitude_clamp.sv =====
// pipeline in order: abs, square, sum, root, compare and multiply, divide, output
// throughput: one word per cycle; the whole pipeline stalls while the output waits
// synchronous active-low reset clears all valid bits; payload is not reset
// the divider depth (63 stages, one quotient bit each) is the largest part of the latency
module vector2_magnitude_clamp #(
    parameter int FRAC_BITS = vmc_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vmc_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output vmc_pkg::t_out_word o_data
);
    `include "vector2_magnitude_clamp_assert.svh"

    localparam int FB = FRAC_BITS;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // stage 1: absolute values
    logic           r_v1;
    vmc_pkg::t_side r_s1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= i_valid;
        if (en) begin
            r_s1.raw_x <= i_data.in_x;
            r_s1.raw_y <= i_data.in_y;
            r_s1.nx    <= i_data.in_x[31];
            r_s1.ny    <= i_data.in_y[31];
            r_s1.ax    <= i_data.in_x[31] ? 32'(-i_data.in_x) : i_data.in_x;
            r_s1.ay    <= i_data.in_y[31] ? 32'(-i_data.in_y) : i_data.in_y;
            r_s1.lim   <= i_data.limit_value;
        end
    end

    // stage 2: squares
    logic           r_v2;
    vmc_pkg::t_side r_s2;
    logic [63:0]    r_sx, r_sy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en) r_v2 <= r_v1;
        if (en) begin
            r_s2 <= r_s1;
            r_sx <= r_s1.ax * r_s1.ax;
            r_sy <= r_s1.ay * r_s1.ay;
        end
    end

    // stage 3: sum
    logic           r_v3;
    vmc_pkg::t_side r_s3;
    logic [63:0]    r_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en) r_v3 <= r_v2;
        if (en) begin
            r_s3  <= r_s2;
            r_sum <= r_sx + r_sy;
        end
    end

    logic           sq_v;
    logic [31:0]    sq_root;
    vmc_pkg::t_side sq_side;
    vmc_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v3),
        .i_rad(r_sum), .i_side(r_s3),
        .o_valid(sq_v), .o_root(sq_root), .o_side(sq_side)
    );

    // stage: compare and products
    logic           r_v4, r_cl4;
    logic [31:0]    r_m4;
    logic [62:0]    r_px, r_py;
    logic [31:0]    r_rx, r_ry;
    logic           r_nx4, r_ny4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (en) r_v4 <= sq_v;
        if (en) begin
            r_cl4 <= sq_root > {1'b0, sq_side.lim};
            r_m4  <= (sq_root > {1'b0, sq_side.lim}) ? sq_root : 32'd1;
            r_px  <= 63'(sq_side.ax * sq_side.lim);
            r_py  <= 63'(sq_side.ay * sq_side.lim);
            r_rx  <= sq_side.raw_x;
            r_ry  <= sq_side.raw_y;
            r_nx4 <= sq_side.nx;
            r_ny4 <= sq_side.ny;
        end
    end

    // pass-through data alongside the dividers
    logic [31:0] r_dx [63];
    logic [31:0] r_dy [63];
    logic [62:0] r_dc;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx[0] <= r_rx;
            r_dy[0] <= r_ry;
            r_dc[0] <= r_cl4;
            for (int k = 1; k < 63; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
                r_dc[k] <= r_dc[k-1];
            end
        end
    end

    logic        dv_x, dv_y, ng_x, ng_y;
    logic [31:0] q_x, q_y;
    vmc_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v4),
        .i_num(r_px), .i_den(r_m4), .i_neg(r_nx4),
        .o_valid(dv_x), .o_quo(q_x), .o_neg(ng_x)
    );
    vmc_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v4),
        .i_num(r_py), .i_den(r_m4), .i_neg(r_ny4),
        .o_valid(dv_y), .o_quo(q_y), .o_neg(ng_y)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= dv_x;
        if (en) begin
            o_data.out_x   <= r_dc[62] ? q_x : r_dx[62];
            o_data.out_y   <= r_dc[62] ? q_y : r_dy[62];
            o_data.clamped <= r_dc[62];
        end
    end

    logic unused_ok;
    assign unused_ok = ng_x ^ ng_y ^ dv_y ^ (FB > 0);

    `VMC_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_data)
    `VMC_ASSERT_IMPL(a_lanes_sync, i_clk, i_rst_n, 1'b1, dv_x == dv_y)
    `VMC_ASSERT_IMPL(a_ready_stall, i_clk, i_rst_n, !o_ready, o_valid)
endmodule

// ===== tb/vmc_checker.sv =====
`timescale 1ns / 1ps
// watches both channels of the vector magnitude clamp, predicts each output word
// and compares it; depends on vmc_pkg for the word types
module vmc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  vmc_pkg::t_in_word  i_data,
    input  logic               o_valid,
    input  logic               i_ready,
    input  vmc_pkg::t_out_word o_data,
    output int                 o_errors,
    output int                 o_pending
);
    import vmc_pkg::*;

    t_out_word clamped_words[$];

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_out_word clamp_vector(t_in_word w);
        t_out_word r;
        logic [63:0] ax, ay, lim, mag, qx, qy;
        ax = w.in_x[31] ? 64'h1_0000_0000 - {32'd0, w.in_x} : {32'd0, w.in_x};
        ay = w.in_y[31] ? 64'h1_0000_0000 - {32'd0, w.in_y} : {32'd0, w.in_y};
        lim = {33'd0, w.limit_value};
        mag = floor_root(ax * ax + ay * ay);
        if (mag > lim) begin
            qx = (ax * lim) / mag;
            qy = (ay * lim) / mag;
            r.out_x = w.in_x[31] ? 32'(0 - qx) : qx[31:0];
            r.out_y = w.in_y[31] ? 32'(0 - qy) : qy[31:0];
            r.clamped = 1'b1;
        end else begin
            r.out_x = w.in_x;
            r.out_y = w.in_y;
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    initial o_errors = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (i_valid && o_ready) clamped_words.push_back(clamp_vector(i_data));
            if (o_valid && i_ready) begin
                if (clamped_words.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected word %h", o_data);
                end else begin
                    want = clamped_words.pop_front();
                    if (want.out_x !== o_data.out_x || want.out_y !== o_data.out_y
                            || want.clamped !== o_data.clamped) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: expected x %h y %h c %b, got x %h y %h c %b",
                                want.out_x, want.out_y, want.clamped,
                                o_data.out_x, o_data.out_y, o_data.clamped);
                    end
                end
            end
            o_pending <= clamped_words.size();
        end
    end
endmodule

// ===== tb/vector2_magnitude_clamp_test.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the vector magnitude clamp: directed corners, then
// random vectors, idling at random but for the last N_QUIET; uses vmc_pkg, vmc_checker
module vector2_magnitude_clamp_test;
    import vmc_pkg::*;

    localparam int N_RANDOM = 750;
    localparam int N_QUIET = 100;
    localparam int WATCHDOG = 5000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_word   i_data = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_word  o_data;
    int         errors;
    int         pending;
    bit         quiet = 1'b0;
    bit         sending = 1'b1;
    int         idle_cycles = 0;

    t_in_word   vectors[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vector2_magnitude_clamp u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    vmc_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word rand_vector();
        t_in_word w;
        w.in_x = rand_comp();
        w.in_y = rand_comp();
        case ($urandom_range(0, 4))
            0: w.limit_value = '0;
            1: w.limit_value = 31'h7fff_ffff;
            2: w.limit_value = 31'($urandom_range(0, 1 << 22));
            default: w.limit_value = 31'($urandom);
        endcase
        return w;
    endfunction

    initial begin
        vectors.push_back('{32'sd0, 32'sd0, 31'd0});
        vectors.push_back('{32'sh0001_0000, 32'sd0, 31'd0});
        vectors.push_back('{32'sh8000_0000, 32'sh8000_0000, 31'd0});
        vectors.push_back('{32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff});
        vectors.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff});
        vectors.push_back('{32'sh8000_0000, 32'sd0, 31'h7fff_ffff});
        vectors.push_back('{32'sh7fff_ffff, 32'sh8000_0000, 31'h0001_0000});
        vectors.push_back('{32'sh0003_0000, 32'sh0004_0000, 31'h0005_0000});
        vectors.push_back('{32'sh0003_0000, 32'shfffc_0000, 31'h0004_ffff});
        vectors.push_back('{-32'sd3, -32'sd4, 31'd1});
        vectors.push_back('{32'sd1, 32'sd1, 31'd1});
        vectors.push_back('{-32'sd1, 32'sd0, 31'd0});
        vectors.push_back('{32'sh5555_5555, 32'shaaaa_aaaa, 31'h5555_5555});
        vectors.push_back('{32'shffff_ffff, 32'shffff_ffff, 31'h2aaa_aaaa});
        for (int k = 0; k < N_RANDOM; k++) vectors.push_back(rand_vector());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < vectors.size(); k++) begin
            if (!quiet && k > 20 && $urandom_range(0, 5) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data <= vectors[k];
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            if (k == vectors.size() - N_QUIET) quiet = 1'b1;
        end
        i_valid <= 1'b0;
        sending = 1'b0;
    end

    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        repeat (40) @(posedge i_clk);
        i_ready <= 1'b0;
        repeat (400) @(posedge i_clk);
        while (1) begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        @(posedge i_clk iff i_rst_n);
        wait (!sending && pending == 0);
        repeat (150) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/vmc_pkg.sv
sv/vmc_sqrt.sv
sv/vmc_div.sv
sv/vector2_magnitude_clamp.sv
tb/vmc_checker.sv
tb/vector2_magnitude_clamp_test.sv
